// ----- src/assert_macros.svh -----
// Assertion helpers included by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BRSS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that forces a consequence in the next cycle.
`define BRSS_ASSERT_NEXT(name, clk, rst_n, cond, conseq, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ----- src/brss_pkg.sv -----
`default_nettype none
package brss_pkg;

	// Field widths fixed by the interface.
	localparam int OFF_W = 63;
	localparam int SEC_W = 47;
	localparam int SB_W  = 17;
	localparam int LEN_W = 18;
	localparam int BNC_W = 16;

	// Largest byte count moved by one whole-sector command.
	localparam int MAX_XFER_BYTES = 131072;

	// Piece phase codes.
	localparam logic [1:0] PH_IDLE      = 2'd0;
	localparam logic [1:0] PH_RMW_READ  = 2'd1;
	localparam logic [1:0] PH_RMW_WRITE = 2'd2;
	localparam logic [1:0] PH_ALIGNED   = 2'd3;

	// Sector size after reset.
	localparam logic [SB_W-1:0] SB_RESET = 17'd512;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap_in;
		logic start_init;
		logic mul_start;
		logic divp_start;
		logic divc_start;
		logic cap_pos;
		logic set_length;
		logic add_span;
		logic emit_finish;
		logic emit_idle;
		logic emit_issue;
		logic emit_wb;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       op;
		logic       ok;
		logic       active;
		logic [1:0] phase;
		logic       wr_req;
		logic       off_ge;
		logic       done_ge_len;
		logic       sb_zero;
		logic       busy;
	} stat_t;

endpackage
`default_nettype wire

// ----- src/brss_arith.sv -----
`default_nettype none
module brss_arith (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     mode_div,
	input  wire logic [63:0]              a,
	input  wire logic [brss_pkg::SB_W-1:0] b,
	output logic                          busy,
	output logic [63:0]                   result,
	output logic [brss_pkg::SB_W-1:0]     rem
);
	import brss_pkg::*;

	logic            busy_q;
	logic            div_q;
	logic [5:0]      cnt_q;
	logic [63:0]     acc_q;
	logic [63:0]     m_q;
	logic [SB_W-1:0] b_q;
	logic [SB_W-1:0] r_q;
	logic [SB_W:0]   rs;
	logic            ge;
	logic [5:0]      last;

	// Restoring division step: shift in the next dividend bit and try a subtract.
	assign rs   = {r_q, acc_q[63]};
	assign ge   = rs >= {1'b0, b_q};
	assign last = div_q ? 6'd63 : 6'(SB_W - 1);

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			div_q  <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			div_q  <= mode_div;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift-add multiply or one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= mode_div ? a : '0;
			m_q   <= a;
			b_q   <= b;
			r_q   <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				r_q   <= ge ? SB_W'(rs - {1'b0, b_q}) : rs[SB_W-1:0];
				acc_q <= {acc_q[62:0], ge};
			end else begin
				acc_q <= acc_q + (b_q[0] ? m_q : 64'd0);
				m_q   <= {m_q[62:0], 1'b0};
				b_q   <= {1'b0, b_q[SB_W-1:1]};
			end
		end
	end

	assign busy   = busy_q;
	assign result = acc_q;
	assign rem    = r_q;
endmodule
`default_nettype wire

// ----- src/brss_datapath.sv -----
`default_nettype none
module brss_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire brss_pkg::cmd_t             cmd,
	output brss_pkg::stat_t                 stat,
	input  wire logic                       cfg_write,
	input  wire logic                       cfg_index,
	input  wire logic [brss_pkg::SEC_W-1:0] cfg_data,
	input  wire logic                       operation,
	input  wire logic [brss_pkg::OFF_W-1:0] byte_offset,
	input  wire logic [brss_pkg::OFF_W-1:0] byte_count,
	input  wire logic                       is_write,
	input  wire logic                       command_ok,
	output logic                            has_command,
	output logic                            command_write,
	output logic [brss_pkg::SEC_W-1:0]      command_sector,
	output logic [brss_pkg::LEN_W-1:0]      command_length,
	output logic [brss_pkg::OFF_W-1:0]      buffer_offset,
	output logic [brss_pkg::BNC_W-1:0]      bounce_offset,
	output logic [brss_pkg::LEN_W-1:0]      copy_bytes,
	output logic                            finished,
	output logic [brss_pkg::OFF_W-1:0]      bytes_done
);
	import brss_pkg::*;

	localparam int CW = $clog2(MAX_XFER_BYTES + 1);

	// Configuration registers.
	logic [SEC_W-1:0] disk_sectors_q;
	logic [SB_W-1:0]  sector_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_sectors_q <= '0;
			sector_bytes_q <= SB_RESET;
		end else if (cfg_write) begin
			if (cfg_index) begin
				sector_bytes_q <= cfg_data[SB_W-1:0];
			end else begin
				disk_sectors_q <= cfg_data;
			end
		end
	end

	// Captured input beat.
	logic             in_op_q;
	logic             in_ok_q;
	logic             in_wr_q;
	logic [OFF_W-1:0] in_off_q;
	logic [OFF_W-1:0] in_size_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			in_op_q   <= operation;
			in_ok_q   <= command_ok;
			in_wr_q   <= is_write;
			in_off_q  <= byte_offset;
			in_size_q <= byte_count;
		end
	end

	// Request state.
	logic             active_q;
	logic [OFF_W-1:0] start_q;
	logic [OFF_W-1:0] length_q;
	logic [OFF_W-1:0] done_q;
	logic             wr_req_q;
	logic [1:0]       phase_q;
	logic [CW-1:0]    span_q;
	logic [SEC_W-1:0] sector_q;
	logic [SB_W-1:0]  ins_q;

	// Shared iterative multiply and divide unit.
	logic            a_start;
	logic            a_busy;
	logic [63:0]     a_in;
	logic [63:0]     a_res;
	logic [SB_W-1:0] a_rem;

	logic [63:0]      pos;
	logic [OFF_W-1:0] rem_len;
	logic [CW-1:0]    chunk;
	logic [63:0]      avail;
	logic [SB_W-1:0]  sb_left;
	logic [CW-1:0]    span_rmw;
	logic             is_rmw;

	assign pos      = {1'b0, start_q} + {1'b0, done_q};
	assign rem_len  = length_q - done_q;
	assign chunk    = (rem_len > OFF_W'(MAX_XFER_BYTES)) ? CW'(MAX_XFER_BYTES)
		: rem_len[CW-1:0];
	assign avail    = a_res - {1'b0, start_q};
	assign sb_left  = sector_bytes_q - ins_q;
	assign span_rmw = (CW'(sb_left) > chunk) ? chunk : CW'(sb_left);
	assign is_rmw   = (ins_q != '0) || (a_rem != '0);

	assign a_start = cmd.mul_start | cmd.divp_start | cmd.divc_start;
	always_comb begin
		priority if (cmd.mul_start) begin
			a_in = {{(64 - SEC_W){1'b0}}, disk_sectors_q};
		end else if (cmd.divp_start) begin
			a_in = pos;
		end else begin
			a_in = 64'(chunk);
		end
	end

	brss_arith u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (a_start),
		.mode_div (!cmd.mul_start),
		.a        (a_in),
		.b        (sector_bytes_q),
		.busy     (a_busy),
		.result   (a_res),
		.rem      (a_rem)
	);

	// Request state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			start_q  <= '0;
			length_q <= '0;
			done_q   <= '0;
			wr_req_q <= 1'b0;
			phase_q  <= PH_IDLE;
			span_q   <= '0;
		end else begin
			if (cmd.start_init) begin
				active_q <= 1'b1;
				start_q  <= in_off_q;
				length_q <= '0;
				done_q   <= '0;
				wr_req_q <= in_wr_q;
				phase_q  <= PH_IDLE;
				span_q   <= '0;
			end
			if (cmd.set_length) begin
				length_q <= ({1'b0, in_size_q} > avail) ? avail[OFF_W-1:0] : in_size_q;
			end
			if (cmd.add_span) begin
				done_q <= done_q + OFF_W'(span_q);
			end
			if (cmd.emit_finish) begin
				active_q <= 1'b0;
				phase_q  <= PH_IDLE;
				span_q   <= '0;
			end
			if (cmd.emit_issue) begin
				phase_q <= is_rmw ? PH_RMW_READ : PH_ALIGNED;
				span_q  <= is_rmw ? span_rmw : chunk;
			end
			if (cmd.emit_wb) begin
				phase_q <= PH_RMW_WRITE;
			end
		end
	end

	// Sector and in-sector offset of the current position.
	always_ff @(posedge clk) begin
		if (cmd.cap_pos) begin
			sector_q <= a_res[SEC_W-1:0];
			ins_q    <= a_rem;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.emit_finish || cmd.emit_idle) begin
			has_command    <= 1'b0;
			command_write  <= 1'b0;
			command_sector <= '0;
			command_length <= '0;
			buffer_offset  <= '0;
			bounce_offset  <= '0;
			copy_bytes     <= '0;
			finished       <= cmd.emit_finish;
			bytes_done     <= done_q;
		end else if (cmd.emit_issue) begin
			has_command    <= 1'b1;
			command_write  <= is_rmw ? 1'b0 : wr_req_q;
			command_sector <= sector_q;
			command_length <= is_rmw ? LEN_W'(sector_bytes_q) : LEN_W'(chunk);
			buffer_offset  <= done_q;
			bounce_offset  <= is_rmw ? ins_q[BNC_W-1:0] : '0;
			copy_bytes     <= is_rmw ? (wr_req_q ? '0 : LEN_W'(span_rmw)) : LEN_W'(chunk);
			finished       <= 1'b0;
			bytes_done     <= done_q;
		end else if (cmd.emit_wb) begin
			has_command    <= 1'b1;
			command_write  <= 1'b1;
			command_sector <= a_res[SEC_W-1:0];
			command_length <= LEN_W'(sector_bytes_q);
			buffer_offset  <= done_q;
			bounce_offset  <= a_rem[BNC_W-1:0];
			copy_bytes     <= LEN_W'(span_q);
			finished       <= 1'b0;
			bytes_done     <= done_q;
		end
	end

	// Status toward the controller.
	assign stat.op          = in_op_q;
	assign stat.ok          = in_ok_q;
	assign stat.active      = active_q;
	assign stat.phase       = phase_q;
	assign stat.wr_req      = wr_req_q;
	assign stat.off_ge      = {1'b0, start_q} >= a_res;
	assign stat.done_ge_len = done_q >= length_q;
	assign stat.sb_zero     = sector_bytes_q == '0;
	assign stat.busy        = a_busy;
endmodule
`default_nettype wire

// ----- src/brss_ctrl.sv -----
`default_nettype none
module brss_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire brss_pkg::stat_t stat,
	output brss_pkg::cmd_t       cmd
);
	import brss_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_MULW   = 3'd2;
	localparam logic [2:0] S_CLAMP  = 3'd3;
	localparam logic [2:0] S_NEXT   = 3'd4;
	localparam logic [2:0] S_DIVPW  = 3'd5;
	localparam logic [2:0] S_DIVCW  = 3'd6;
	localparam logic [2:0] S_WBW    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       emit;

	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign emit     = cmd.emit_finish | cmd.emit_idle | cmd.emit_issue | cmd.emit_wb;

	// Sequencer for one beat.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					cmd.cap_in = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!stat.op) begin
					cmd.start_init = 1'b1;
					cmd.mul_start  = 1'b1;
					state_d        = S_MULW;
				end else if (!stat.active) begin
					cmd.emit_idle = 1'b1;
					state_d       = S_IDLE;
				end else if (!stat.ok || stat.phase == PH_IDLE || stat.sb_zero) begin
					cmd.emit_finish = 1'b1;
					state_d         = S_IDLE;
				end else if (stat.phase == PH_RMW_READ && stat.wr_req) begin
					cmd.divp_start = 1'b1;
					state_d        = S_WBW;
				end else begin
					cmd.add_span = 1'b1;
					state_d      = S_NEXT;
				end
			end
			S_MULW: begin
				if (!stat.busy) begin
					state_d = S_CLAMP;
				end
			end
			S_CLAMP: begin
				if (stat.off_ge) begin
					cmd.emit_finish = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.set_length = 1'b1;
					state_d        = S_NEXT;
				end
			end
			S_NEXT: begin
				if (stat.done_ge_len || stat.sb_zero) begin
					cmd.emit_finish = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.divp_start = 1'b1;
					state_d        = S_DIVPW;
				end
			end
			S_DIVPW: begin
				if (!stat.busy) begin
					cmd.cap_pos    = 1'b1;
					cmd.divc_start = 1'b1;
					state_d        = S_DIVCW;
				end
			end
			S_DIVCW: begin
				if (!stat.busy) begin
					cmd.emit_issue = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_WBW: begin
				if (!stat.busy) begin
					cmd.emit_wb = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ----- src/block_request_sector_splitter_top.sv -----
`default_nettype none
// Splits a byte-range disk request into device commands, one result beat per input
// beat. A start beat (operation 0) clamps the range to the disk and yields the first
// command or an immediate finish; a completion beat (operation 1) yields the next
// command or the final byte count. One beat is handled at a time. Between the input
// accept and the loading of the result, a start runs the disk size multiply and
// clamp and then two 64-step divisions by the sector size in a shared
// shift-and-subtract unit, a completion two such divisions, a write back of a
// partial sector one, and a beat that ends the request or is ignored none or
// only the multiply. The result fields and out_valid are registered together, and
// the next input beat is taken once the previous result beat has been taken.
module block_request_sector_splitter_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire logic                       cfg_index,
	input  wire logic [brss_pkg::SEC_W-1:0] cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       operation,
	input  wire logic [brss_pkg::OFF_W-1:0] byte_offset,
	input  wire logic [brss_pkg::OFF_W-1:0] byte_count,
	input  wire logic                       is_write,
	input  wire logic                       command_ok,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            has_command,
	output logic                            command_write,
	output logic [brss_pkg::SEC_W-1:0]      command_sector,
	output logic [brss_pkg::LEN_W-1:0]      command_length,
	output logic [brss_pkg::OFF_W-1:0]      buffer_offset,
	output logic [brss_pkg::BNC_W-1:0]      bounce_offset,
	output logic [brss_pkg::LEN_W-1:0]      copy_bytes,
	output logic                            finished,
	output logic [brss_pkg::OFF_W-1:0]      bytes_done
);
	import brss_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	brss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	brss_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.operation      (operation),
		.byte_offset    (byte_offset),
		.byte_count     (byte_count),
		.is_write       (is_write),
		.command_ok     (command_ok),
		.has_command    (has_command),
		.command_write  (command_write),
		.command_sector (command_sector),
		.command_length (command_length),
		.buffer_offset  (buffer_offset),
		.bounce_offset  (bounce_offset),
		.copy_bytes     (copy_bytes),
		.finished       (finished),
		.bytes_done     (bytes_done)
	);

	`include "assert_macros.svh"

	// No new beat is taken while a result beat is pending.
	`BRSS_ASSERT(a_no_early_in, clk, arst_n, !(in_valid && !in_stall && out_valid), "early take")
	// A pending result stays until taken.
	`BRSS_ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && out_stall, out_valid, "result dropped")
	// A finishing result carries no command.
	`BRSS_ASSERT(a_fin_clean, clk, arst_n, !(out_valid && finished && has_command), "cmd on finish")
	// An accepted beat keeps the block busy in the next cycle.
	`BRSS_ASSERT_NEXT(a_busy_next, clk, arst_n, in_valid && !in_stall, in_stall, "idle after accept")
endmodule
`default_nettype wire
